@@ rtl/ghal_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types for the generational handle allocator.
package ghal_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int IDX_W      = 10;
	localparam int GEN_W      = 16;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int ENTRY_W    = GEN_W + 1;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ghal_state_t;

	typedef struct packed {
		logic ready;
		logic accept;
		logic execute;
	} ghal_cmd_t;

	typedef struct packed {
		logic rsp_free;
	} ghal_sts_t;

endpackage

@@ rtl/ghal_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: one beat carries an allocate, free or check request.
interface ghal_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  handle_index;
	logic [15:0] handle_gen;

	modport source (output valid, output action, output handle_index, output handle_gen,
		input ready);
	modport sink (input valid, input action, input handle_index, input handle_gen,
		output ready);
endinterface

@@ rtl/ghal_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: one beat carries the result of one request.
interface ghal_rsp_if;
	logic        valid;
	logic        ready;
	logic [9:0]  new_index;
	logic [15:0] new_gen;
	logic        is_alive;
	logic        table_full;

	modport source (output valid, output new_index, output new_gen, output is_alive,
		output table_full, input ready);
	modport sink (input valid, input new_index, input new_gen, input is_alive,
		input table_full, output ready);
endinterface

@@ rtl/ghal_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ghal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/ghal_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences each request through a read cycle and an execute cycle.
module ghal_ctrl
	import ghal_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  ghal_sts_t sts,
	output ghal_cmd_t cmd
);

	ghal_state_t state_q;
	ghal_state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && sts.rsp_free) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready  = sts.rsp_free;
				cmd.accept = req_valid && sts.rsp_free;
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/ghal_dp.sv @@
`timescale 1ns / 1ps
// Datapath: slot tables, free-list head, fill count and the response register.
module ghal_dp
	import ghal_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ghal_cmd_t         cmd,
	output ghal_sts_t         sts,
	input  logic [1:0]        action,
	input  logic [IDX_W-1:0]  handle_index,
	input  logic [GEN_W-1:0]  handle_gen,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output logic [IDX_W-1:0]  new_index,
	output logic [GEN_W-1:0]  new_gen,
	output logic              is_alive,
	output logic              table_full
);

	logic [IDX_W-1:0] free_head_q;
	logic [CNT_W-1:0] used_count_q;
	logic             rsp_valid_q;

	// Request captured at accept.
	logic [1:0]       action_s1;
	logic [IDX_W-1:0] slot_s1;
	logic [GEN_W-1:0] gen_s1;
	logic             use_list_s1;
	logic             rd_valid_s1;
	logic             room_s1;

	logic             is_alloc;
	logic             use_list;
	logic [IDX_W-1:0] slot_sel;
	logic             rd_valid;

	logic [ENTRY_W-1:0] entry_rdata;
	logic [IDX_W-1:0]   link_rdata;
	logic               entry_alive;
	logic [GEN_W-1:0]   entry_gen;
	logic [GEN_W-1:0]   gen_next;
	logic               alloc_ok;
	logic               do_alloc;
	logic               do_free;
	logic               entry_we;
	logic [ENTRY_W-1:0] entry_wdata;

	assign is_alloc = (action == ACT_ALLOC);
	assign use_list = (free_head_q != '0);
	assign slot_sel = !is_alloc ? handle_index :
		(use_list ? free_head_q : used_count_q[IDX_W-1:0]);
	// Slot 0 and slots at or above the fill count were never allocated: dead,
	// generation zero.
	assign rd_valid = (slot_sel != '0) && ({1'b0, slot_sel} < used_count_q);

	assign entry_alive = rd_valid_s1 && entry_rdata[GEN_W];
	assign entry_gen   = rd_valid_s1 ? entry_rdata[GEN_W-1:0] : '0;
	assign gen_next    = entry_gen + GEN_W'(1);
	assign alloc_ok    = use_list_s1 || room_s1;
	assign do_alloc    = cmd.execute && (action_s1 == ACT_ALLOC) && alloc_ok;
	assign do_free     = cmd.execute && (action_s1 == ACT_FREE) && entry_alive;
	assign entry_we    = do_alloc || do_free;
	assign entry_wdata = do_alloc ? {1'b1, gen_next} : {1'b0, entry_gen};

	ghal_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_entry_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (slot_s1),
		.wdata (entry_wdata),
		.re    (cmd.accept),
		.raddr (slot_sel),
		.rdata (entry_rdata)
	);

	ghal_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_link_ram (
		.clk   (clk),
		.we    (do_free),
		.waddr (slot_s1),
		.wdata (free_head_q),
		.re    (cmd.accept),
		.raddr (slot_sel),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_s1   <= action;
			slot_s1     <= slot_sel;
			gen_s1      <= handle_gen;
			use_list_s1 <= use_list;
			rd_valid_s1 <= rd_valid;
			room_s1     <= (used_count_q < CNT_W'(SLOT_COUNT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			used_count_q <= CNT_W'(1);
		end else begin
			if (do_alloc && use_list_s1) begin
				free_head_q <= link_rdata;
			end else if (do_free) begin
				free_head_q <= slot_s1;
			end
			if (do_alloc && !use_list_s1) begin
				used_count_q <= used_count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			new_index  <= do_alloc ? slot_s1 : '0;
			new_gen    <= do_alloc ? gen_next : '0;
			is_alive   <= (action_s1 == ACT_CHECK) && entry_alive && (entry_gen == gen_s1);
			table_full <= (action_s1 == ACT_ALLOC) && !alloc_ok;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign sts.rsp_free = !rsp_valid_q || rsp_ready;

endmodule

@@ rtl/generational_handle_allocator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the generational handle allocator.
// Each request beat (allocate, free or check) first reads the slot entry and
// its free-list link from on-chip RAM at the selected slot, then the entry
// is updated and the response is loaded into the output register. The next
// request is accepted only after that, while the response register is free
// or being taken. Allocation pops the most recently freed slot, otherwise
// the next never-used slot; slot 0 is never handed out. A fill count marks
// which slots were ever used, so the tables need no clearing pass after
// reset and the block accepts requests right after reset is released.
module generational_handle_allocator_unit
	import ghal_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	ghal_req_if.sink req,
	ghal_rsp_if.source rsp
);

	ghal_cmd_t cmd;
	ghal_sts_t sts;

	ghal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	ghal_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (req.action),
		.handle_index (req.handle_index),
		.handle_gen   (req.handle_gen),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.new_index    (rsp.new_index),
		.new_gen      (rsp.new_gen),
		.is_alive     (rsp.is_alive),
		.table_full   (rsp.table_full)
	);

	assign req.ready = cmd.ready;

endmodule

@@ rtl/ghal_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the handle allocator and its bind to the top level.
module ghal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [9:0]  new_index,
	input logic [15:0] new_gen,
	input logic        is_alive,
	input logic        table_full
);

	// A held response must stay until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// Requests are processed one at a time, so an accepted beat blocks the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// A full table hands out no slot.
	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && table_full |-> new_index == 10'd0 && new_gen == 16'd0)
		else $error("slot returned together with the full flag");

	// A check never returns a slot, and an allocate never reports alive.
	a_alive_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_alive |-> new_index == 10'd0 && !table_full)
		else $error("check result mixed with allocate result");

endmodule

bind generational_handle_allocator_unit ghal_checker u_ghal_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.new_index  (rsp.new_index),
	.new_gen    (rsp.new_gen),
	.is_alive   (rsp.is_alive),
	.table_full (rsp.table_full)
);
